// ===== hdl/spi_clock_divider_setup_defines.svh =====
// Assertion macros shared by the serial clock divider setup block.
`ifndef SPI_CLOCK_DIVIDER_SETUP_DEFINES_SVH
`define SPI_CLOCK_DIVIDER_SETUP_DEFINES_SVH

// Condition and consequence in the same cycle.
`define SCDS_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scds: same-cycle check failed");

// Consequence in the cycle after the condition.
`define SCDS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scds: next-cycle check failed");

`endif

// ===== hdl/scds_pkg.sv =====
package scds_pkg;

   // Divider limits and word width window.
   localparam logic [7:0]  SCR_MAX       = 8'd255;
   localparam logic [7:0]  PRESCALE_MIN  = 8'd2;
   localparam logic [7:0]  PRESCALE_MAX  = 8'd254;
   localparam logic [5:0]  WORD_MIN      = 6'd4;
   localparam logic [5:0]  WORD_MAX      = 6'd16;

   // The smallest even prescale 2k with maxdiv / 2k <= 256 has k = maxdiv / 514 + 1.
   localparam logic [31:0] SEARCH_STEP   = 32'd514;
   // A step quotient of this or more would need a prescale beyond the maximum.
   localparam logic [31:0] STEP_LIMIT    = 32'd127;

   // Register map and reset value.
   localparam logic [1:0]  CSR_ADDR_SYSCLK = 2'd0;
   localparam logic [31:0] SYSCLK_RESET    = 32'd50000000;

   // Status codes.
   localparam logic [1:0]  STATUS_OK        = 2'd0;
   localparam logic [1:0]  STATUS_ZERO_RATE = 2'd1;
   localparam logic [1:0]  STATUS_TOO_SLOW  = 2'd2;

   typedef struct packed {
      logic [31:0] target_hz;
      logic [1:0]  spi_mode;
      logic [5:0]  word_bits;
   } req_type;

   typedef struct packed {
      logic [7:0] prescale;
      logic [7:0] serial_rate;
      logic       phase_bit;
      logic       polarity_bit;
      logic [3:0] size_code;
      logic       rate_clamped;
      logic [1:0] status;
   } rsp_type;

   // Command to the serial divider.
   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_cmd_type;

   // Answer from the serial divider.
   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_res_type;

endpackage

// ===== hdl/scds_div.sv =====
module scds_div
   import scds_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_res_type res
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  count_ff, count_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] den_ff, den_in;
   logic [32:0] trial;

   // One restoring step: bring down the next dividend bit and try the divisor.
   assign trial = {rem_ff, quo_ff[31]} - {1'b0, den_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      if (cmd.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = cmd.dividend;
         den_in   = cmd.divisor;
      end else if (busy_ff) begin
         // The quotient bit enters where the dividend bit left.
         if (!trial[32]) begin
            rem_in = trial[31:0];
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
         end
         quo_in   = {quo_ff[30:0], !trial[32]};
         count_in = count_ff + 5'd1;
         if (count_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign res.done     = done_ff;
   assign res.quotient = quo_ff;

endmodule

// ===== hdl/scds_ctrl.sv =====
module scds_ctrl
   import scds_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] sysclk_hz,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   output div_cmd_type div_cmd,
   input  div_res_type div_res
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV_MAX,
      S_DIV_PRE,
      S_DIV_SCR,
      S_DONE
   } state_type;

   state_type   state_ff, state_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic        start_ff, start_in;
   logic [31:0] num_ff, num_in;
   logic [31:0] den_ff, den_in;
   logic [31:0] maxdiv_ff, maxdiv_in;
   logic [7:0]  pre_ff, pre_in;
   logic [7:0]  scr_ff, scr_in;
   logic [1:0]  status_ff, status_in;
   logic        clamped_ff, clamped_in;
   logic [1:0]  mode_ff, mode_in;
   logic [3:0]  size_ff, size_in;

   logic [31:0] half_hz;
   logic        over_half;
   logic [31:0] rate_eff;
   logic [5:0]  bits_dec;
   logic [6:0]  step_inc;
   logic [31:0] quo_dec;

   // Request side: clamp to half the system clock and decode the word size.
   assign half_hz   = sysclk_hz >> 1;
   assign over_half = req_data.target_hz > half_hz;
   assign rate_eff  = over_half ? half_hz : req_data.target_hz;
   assign bits_dec  = req_data.word_bits - 6'd1;

   // Result side of the divisions.
   assign step_inc = div_res.quotient[6:0] + 7'd1;
   assign quo_dec  = div_res.quotient - 32'd1;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      start_in     = 1'b0;
      num_in       = num_ff;
      den_in       = den_ff;
      maxdiv_in    = maxdiv_ff;
      pre_in       = pre_ff;
      scr_in       = scr_ff;
      status_in    = status_ff;
      clamped_in   = clamped_ff;
      mode_in      = mode_ff;
      size_in      = size_ff;

      // The output word leaves when taken.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in = req_data.spi_mode;
               if (req_data.word_bits >= WORD_MIN && req_data.word_bits <= WORD_MAX) begin
                  size_in = bits_dec[3:0];
               end else begin
                  size_in = 4'd0;
               end
               if (req_data.target_hz == 32'd0) begin
                  clamped_in = 1'b0;
                  pre_in     = PRESCALE_MAX;
                  scr_in     = SCR_MAX;
                  status_in  = STATUS_ZERO_RATE;
                  state_in   = S_DONE;
               end else if (rate_eff == 32'd0) begin
                  // A system clock below two gives a divide ratio of zero.
                  clamped_in = over_half;
                  pre_in     = PRESCALE_MIN;
                  scr_in     = 8'd0;
                  status_in  = STATUS_OK;
                  state_in   = S_DONE;
               end else begin
                  clamped_in = over_half;
                  start_in   = 1'b1;
                  num_in     = sysclk_hz;
                  den_in     = rate_eff;
                  state_in   = S_DIV_MAX;
               end
            end
         end
         S_DIV_MAX: begin
            // Overall ratio known; find the prescale step.
            if (div_res.done) begin
               maxdiv_in = div_res.quotient;
               start_in  = 1'b1;
               num_in    = div_res.quotient;
               den_in    = SEARCH_STEP;
               state_in  = S_DIV_PRE;
            end
         end
         S_DIV_PRE: begin
            if (div_res.done) begin
               if (div_res.quotient >= STEP_LIMIT) begin
                  pre_in    = PRESCALE_MAX;
                  scr_in    = SCR_MAX;
                  status_in = STATUS_TOO_SLOW;
                  state_in  = S_DONE;
               end else begin
                  pre_in   = {step_inc, 1'b0};
                  start_in = 1'b1;
                  num_in   = maxdiv_ff;
                  den_in   = {24'd0, step_inc, 1'b0};
                  state_in = S_DIV_SCR;
               end
            end
         end
         S_DIV_SCR: begin
            // The quotient is at most 256 here, so its decrement fits eight bits.
            if (div_res.done) begin
               if (div_res.quotient == 32'd0) begin
                  scr_in = 8'd0;
               end else begin
                  scr_in = quo_dec[7:0];
               end
               status_in = STATUS_OK;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.prescale     = pre_ff;
               rsp_in.serial_rate  = scr_ff;
               rsp_in.phase_bit    = mode_ff[0];
               rsp_in.polarity_bit = mode_ff[1];
               rsp_in.size_code    = size_ff;
               rsp_in.rate_clamped = clamped_ff;
               rsp_in.status       = status_ff;
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         start_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         start_ff     <= start_in;
      end
      rsp_ff     <= rsp_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      maxdiv_ff  <= maxdiv_in;
      pre_ff     <= pre_in;
      scr_ff     <= scr_in;
      status_ff  <= status_in;
      clamped_ff <= clamped_in;
      mode_ff    <= mode_in;
      size_ff    <= size_in;
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_ff;
   assign div_cmd.start    = start_ff;
   assign div_cmd.dividend = num_ff;
   assign div_cmd.divisor  = den_ff;

endmodule

// ===== hdl/spi_clock_divider_setup.sv =====
// Channel  Handshake                         Word
// req      req_valid / req_ready             req_data (target_hz, spi_mode, word_bits)
// rsp      rsp_valid / rsp_ready             rsp_data (prescale ... status)
// csr      csr_psel, csr_penable / pready    system_clock_hz at address 0
//
// One word is worked on at a time. An accepted request with a zero rate or a system clock
// below two goes straight to the result; a rate that is too slow takes two divisions and
// any other rate three, each in the shared serial divider at one quotient bit a cycle.
// Reset is synchronous and needs no clearing pass. A finished result waits in the output
// register while the next request is taken; the word after that waits until the output
// register is free.
`include "spi_clock_divider_setup_defines.svh"

module spi_clock_divider_setup
   import scds_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [31:0] sysclk_ff, sysclk_in;
   div_cmd_type div_cmd;
   div_res_type div_res;

   // Configuration register.
   always_comb begin
      sysclk_in = sysclk_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_ADDR_SYSCLK) begin
         sysclk_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sysclk_ff <= SYSCLK_RESET;
      end else begin
         sysclk_ff <= sysclk_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_ADDR_SYSCLK) ? sysclk_ff : 32'd0;

   // Sequencer and the shared serial divider.
   scds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .sysclk_hz (sysclk_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .div_cmd   (div_cmd),
      .div_res   (div_res)
   );

   scds_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   // Checks on the sequencer and its results.
   `SCDS_ASSERT_SAME(a_zero_rate_slowest, rsp_valid && rsp_data.status == STATUS_ZERO_RATE, rsp_data.prescale == PRESCALE_MAX && rsp_data.serial_rate == SCR_MAX)
   `SCDS_ASSERT_SAME(a_prescale_even, rsp_valid, !rsp_data.prescale[0] && rsp_data.prescale >= PRESCALE_MIN)
   `SCDS_ASSERT_SAME(a_divisor_nonzero, div_cmd.start, div_cmd.divisor != 32'd0)
   `SCDS_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)

endmodule

// ===== bench/tb.sv =====
module tb;
   import scds_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [1:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Words waiting to be offered, and divider settings waiting to come back.
   req_type     pending_words[$];
   rsp_type     expected_setups[$];

   logic [31:0] sysclk_model = SYSCLK_RESET;
   int          words_queued = 0;
   int          words_taken = 0;
   int          setups_seen = 0;
   int          mismatches = 0;
   int          hold_requests = 0;
   bit          sender_burst = 1'b0;
   bit          receiver_burst = 1'b0;

   // Sender and receiver bookkeeping, owned by their own processes.
   int          send_seen = 0;
   int          send_gap = 0;
   bit          send_active = 1'b0;
   int          recv_seen = 0;
   int          recv_hold_seen = 0;
   int          recv_gap = 0;

   spi_clock_divider_setup dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Works out the divider setting that one request word should produce.
   function automatic rsp_type divider_setting(req_type word, logic [31:0] sysclk);
      rsp_type     setup;
      logic [31:0] rate;
      logic [31:0] maxdiv;
      logic [31:0] quot;
      logic [31:0] pre;
      bit          found;
      setup = '0;
      setup.phase_bit = word.spi_mode[0];
      setup.polarity_bit = word.spi_mode[1];
      if (word.word_bits >= WORD_MIN && word.word_bits <= WORD_MAX) begin
         setup.size_code = 4'(word.word_bits - 6'd1);
      end
      rate = word.target_hz;
      setup.prescale = PRESCALE_MAX;
      setup.serial_rate = SCR_MAX;
      if (rate == 32'd0) begin
         setup.status = STATUS_ZERO_RATE;
      end else begin
         // Requests above half the system clock are pulled down to it.
         if (rate > (sysclk >> 1)) begin
            rate = sysclk >> 1;
            setup.rate_clamped = 1'b1;
         end
         maxdiv = (rate == 32'd0) ? 32'd0 : sysclk / rate;
         setup.status = STATUS_TOO_SLOW;
         found = 1'b0;
         // Smallest even prescale whose remaining quotient fits the second divider.
         for (pre = 32'(PRESCALE_MIN); pre <= 32'(PRESCALE_MAX) && !found; pre += 32'd2) begin
            quot = maxdiv / pre;
            if (quot <= 32'd256) begin
               found = 1'b1;
               setup.prescale = pre[7:0];
               setup.serial_rate = (quot == 32'd0) ? 8'd0 : 8'(quot - 32'd1);
               setup.status = STATUS_OK;
            end
         end
      end
      return setup;
   endfunction

   task automatic report(string field, logic [31:0] want, logic [31:0] got);
      if (mismatches < 10) begin
         $display("mismatch in %s: expected %0d, got %0d", field, want, got);
      end
      mismatches++;
   endtask

   // Monitor: predicts on every accepted request word and checks every result word.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_setups.push_back(divider_setting(req_data, sysclk_model));
            words_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            setups_seen++;
            if (expected_setups.size() == 0) begin
               report("unexpected result word", 32'd0, 32'(rsp_data));
            end else begin
               want = expected_setups.pop_front();
               if (rsp_data.prescale !== want.prescale)
                  report("prescale", 32'(want.prescale), 32'(rsp_data.prescale));
               if (rsp_data.serial_rate !== want.serial_rate)
                  report("serial_rate", 32'(want.serial_rate), 32'(rsp_data.serial_rate));
               if (rsp_data.phase_bit !== want.phase_bit)
                  report("phase_bit", 32'(want.phase_bit), 32'(rsp_data.phase_bit));
               if (rsp_data.polarity_bit !== want.polarity_bit)
                  report("polarity_bit", 32'(want.polarity_bit),
                         32'(rsp_data.polarity_bit));
               if (rsp_data.size_code !== want.size_code)
                  report("size_code", 32'(want.size_code), 32'(rsp_data.size_code));
               if (rsp_data.rate_clamped !== want.rate_clamped)
                  report("rate_clamped", 32'(want.rate_clamped),
                         32'(rsp_data.rate_clamped));
               if (rsp_data.status !== want.status)
                  report("status", 32'(want.status), 32'(rsp_data.status));
            end
         end
      end
   end

   // Driver: offers pending words, with a random gap after each taken word outside burst mode.
   always @(negedge clock) begin
      if (!reset) begin
         if (send_active && words_taken != send_seen) begin
            send_seen = words_taken;
            send_active = 1'b0;
            send_gap = sender_burst ? 0 : $urandom_range(0, 10);
         end
         if (!send_active) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_words.size() > 0) begin
               req_data <= pending_words.pop_front();
               send_active = 1'b1;
            end
         end
         req_valid <= send_active;
      end
   end

   // Receiver: random stall after each word outside burst mode, and a long hold-off when asked.
   always @(negedge clock) begin
      if (!reset) begin
         if (setups_seen != recv_seen) begin
            recv_seen = setups_seen;
            recv_gap = receiver_burst ? 0 : $urandom_range(0, 10);
         end
         if (hold_requests != recv_hold_seen) begin
            recv_hold_seen = hold_requests;
            recv_gap = 400;
         end
         if (recv_gap > 0) begin
            rsp_ready <= 1'b0;
            recv_gap--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic queue_word(logic [31:0] target, logic [1:0] mode, logic [5:0] bits);
      req_type word;
      word.target_hz = target;
      word.spi_mode = mode;
      word.word_bits = bits;
      pending_words.push_back(word);
      words_queued++;
   endtask

   // Random requests, weighted towards the divider boundaries of the current clock.
   task automatic queue_random(int count);
      logic [31:0] target;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0:       target = 32'd0;
            1, 2:    target = $urandom;
            3, 4, 5: target = $urandom >> $urandom_range(0, 31);
            6:       target = (sysclk_model >> 1) + $urandom_range(0, 2) - 32'd1;
            7:       target = sysclk_model / $urandom_range(1, 70000);
            default: target = $urandom_range(1, 200000);
         endcase
         queue_word(target, 2'($urandom_range(0, 3)), 6'($urandom_range(0, 32)));
      end
   endtask

   // The sender waits here until every result word has come back.
   task automatic wait_drained();
      while (setups_seen < words_queued) @(negedge clock);
   endtask

   task automatic write_sysclk(logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_SYSCLK;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sysclk_model = value;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words at the reset clock of 50 MHz.
      queue_word(32'd0, 2'd0, 6'd0);
      queue_word(32'd0, 2'd3, 6'd16);
      queue_word(32'hFFFFFFFF, 2'd1, 6'd4);
      queue_word(32'hFFFFFFFF, 2'd2, 6'd32);
      queue_word(32'd25000000, 2'd3, 6'd3);
      queue_word(32'd25000001, 2'd0, 6'd17);
      queue_word(32'd24999999, 2'd1, 6'd8);
      queue_word(32'd1, 2'd2, 6'd12);
      queue_word(32'd765, 2'd3, 6'd15);
      queue_word(32'd766, 2'd0, 6'd5);
      queue_word(32'd97465, 2'd1, 6'd31);
      queue_word(32'd97466, 2'd2, 6'd1);
      queue_word(32'd97656, 2'd3, 6'd2);
      queue_word(32'd1000000, 2'd0, 6'd16);
      queue_word(32'd400000, 2'd1, 6'd9);
      queue_word(32'd196, 2'd2, 6'd10);
      queue_word(32'd12345, 2'd3, 6'd11);
      queue_word(32'h80000000, 2'd0, 6'd13);
      queue_word(32'd2, 2'd1, 6'd14);
      queue_word(32'd5000, 2'd2, 6'd6);
      queue_word(32'd48000, 2'd3, 6'd7);
      queue_random(120);
      wait_drained();

      // Smallest legal system clock.
      write_sysclk(32'd2);
      queue_word(32'd0, 2'd0, 6'd4);
      queue_word(32'd1, 2'd1, 6'd16);
      queue_word(32'd2, 2'd2, 6'd0);
      queue_word(32'hFFFFFFFF, 2'd3, 6'd32);
      queue_random(50);
      wait_drained();

      // Largest system clock, with a long receiver hold-off so the block backs up.
      write_sysclk(32'hFFFFFFFF);
      queue_word(32'hFFFFFFFF, 2'd0, 6'd16);
      queue_word(32'h7FFFFFFF, 2'd1, 6'd4);
      queue_word(32'h80000000, 2'd2, 6'd3);
      queue_word(32'd1, 2'd3, 6'd17);
      queue_random(150);
      hold_requests++;
      wait_drained();

      // A clock below two leaves nothing to divide.
      write_sysclk(32'd1);
      queue_random(30);
      wait_drained();

      // A random clock with no idling on either side.
      write_sysclk($urandom_range(2, 32'hFFFFFFFF));
      sender_burst = 1'b1;
      receiver_burst = 1'b1;
      queue_random(120);
      wait_drained();
      sender_burst = 1'b0;
      receiver_burst = 1'b0;

      write_sysclk(32'd100000000);
      queue_random(120);
      hold_requests++;
      wait_drained();

      write_sysclk(SYSCLK_RESET);
      queue_random(100);
      wait_drained();

      repeat (150) @(negedge clock);
      if (expected_setups.size() != 0) begin
         report("result words still outstanding", 32'(expected_setups.size()), 32'd0);
      end
      if (mismatches == 0) begin
         $display("PASS spi_clock_divider_setup");
      end else begin
         $display("FAIL spi_clock_divider_setup");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #(12 * 2000000);
      $display("FAIL spi_clock_divider_setup");
      $finish;
   end

endmodule
